[hdl/armp_pkg.sv]
// armp_pkg: shared types and constants for the audio rms / peak meter
// used by armp_cmp_sub and audio_rms_peak_meter_unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package armp_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int LEVEL_W      = 16;
   localparam int CELLS_W      = 4;
   localparam int CNT_W        = 13;
   localparam int SQUARE_W     = 2 * LEVEL_W;
   localparam int SUM_W        = 43;
   localparam int MEAN_W       = 31;
   localparam int REM_W        = CNT_W + 1;
   localparam int STEP_W       = 6;
   localparam int DIV_STEPS    = SUM_W;
   localparam int SQRT_STEPS   = (MEAN_W + 1) / 2;
   localparam int BAR_CELLS    = 10;
   localparam int BAR_MUL_W    = $clog2(BAR_CELLS + 1);
   localparam int SCALED_W     = LEVEL_W + BAR_MUL_W;
   localparam int FULL_SCALE_SHIFT = 15;
   localparam int MAX_WINDOW   = 4096;
   localparam int WINDOW_RESET = 800;
   localparam int RSP_TDATA_W  = 40;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_DIV,
      ST_SQRT,
      ST_DONE
   } armp_state_type;

   typedef struct packed {
      logic              ge;
      logic [MEAN_W-1:0] diff;
   } armp_cmp_result_type;

endpackage

`default_nettype wire

[hdl/armp_cmp_sub.sv]
// armp_cmp_sub: shared compare-and-subtract unit
// serves the restoring divider and the bitwise square root; uses armp_pkg
`timescale 1ns / 1ps
`default_nettype none

module armp_cmp_sub (
   input  wire logic [armp_pkg::MEAN_W-1:0] op_a,
   input  wire logic [armp_pkg::MEAN_W-1:0] op_b,
   output armp_pkg::armp_cmp_result_type    result
);
   import armp_pkg::*;

   always_comb begin
      result.ge   = (op_a >= op_b);
      result.diff = op_a - op_b;
   end

endmodule

`default_nettype wire

[hdl/audio_rms_peak_meter_unit.sv]
// audio_rms_peak_meter_unit: top level of the audio rms / peak level meter
// depends on armp_pkg and armp_cmp_sub
`timescale 1ns / 1ps
`default_nettype none

// usage
//  req channel: one signed 16-bit sample per word (req_tdata[15:0])
//  rsp channel: one report word per finished window
//    rms level [15:0], peak level [31:16], bar cells [35:32], zero pad above
//  csr_wr_en / csr_wr_data set the window length in samples; 0 acts as 1,
//  values above 4096 act as 4096; write only while the block is idle
// timing
//  a sample that does not close a window passes the accept, square and add steps
//  a closing sample passes square and add, then the one-bit-per-cycle divider,
//  the square root and a load of the output register; both loops share one
//  compare/subtract unit
//  req_tready is high only while the sequencer waits for a sample
// reset
//  synchronous, active high: accumulators clear, window returns to 800,
//  output register empties
// back pressure
//  a report waits in the output register while rsp_tready is low; the next
//  samples are still taken, and only a following report stalls until the
//  register frees up
module audio_rms_peak_meter_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] sample
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [15:0] rms_level, [31:16] peak_level,
                                         // [35:32] bar_cells, [39:36] zero
   input  wire logic        csr_wr_en,
   input  wire logic [12:0] csr_wr_data  // [12:0] window_samples
);
   import armp_pkg::*;

   // sequencer state
   armp_state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // configuration
   logic [CNT_W-1:0] window_ff, window_in;

   // window accumulators
   logic [LEVEL_W-1:0]  mag_ff, mag_in;
   logic [SQUARE_W-1:0] square_ff, square_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [LEVEL_W-1:0]  peak_ff, peak_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   // end-of-window working registers
   logic [CNT_W-1:0]   divisor_ff, divisor_in;
   logic [LEVEL_W-1:0] rpt_peak_ff, rpt_peak_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [SUM_W-1:0]   dvd_ff, dvd_in;
   logic [MEAN_W-1:0]  rad_ff, rad_in;
   logic [MEAN_W-1:0]  root_ff, root_in;
   logic [MEAN_W-1:0]  bit_ff, bit_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // shared unit
   logic [MEAN_W-1:0]   op_a, op_b;
   armp_cmp_result_type cmp;

   // helpers
   logic [CNT_W-1:0]     eff_window;
   logic [CNT_W-1:0]     count_inc;
   logic [SUM_W-1:0]     sum_next;
   logic [LEVEL_W-1:0]   peak_next;
   logic [REM_W-1:0]     div_cand;
   logic [SUM_W-1:0]     dvd_next;
   logic [SCALED_W-1:0]  scaled;
   logic [SCALED_W-FULL_SCALE_SHIFT-1:0] cells_raw;
   logic [CELLS_W-1:0]   cells;

   armp_cmp_sub u_cmp (
      .op_a   (op_a),
      .op_b   (op_b),
      .result (cmp)
   );

   // window length as used: zero acts as one, large values saturate
   always_comb begin
      priority if (window_ff == '0) begin
         eff_window = CNT_W'(1);
      end else if (window_ff > CNT_W'(MAX_WINDOW)) begin
         eff_window = CNT_W'(MAX_WINDOW);
      end else begin
         eff_window = window_ff;
      end
   end

   assign count_inc = count_ff + CNT_W'(1);
   assign sum_next  = sum_ff + SUM_W'(square_ff);
   assign peak_next = (mag_ff > peak_ff) ? mag_ff : peak_ff;
   assign div_cand  = {rem_ff[REM_W-2:0], dvd_ff[SUM_W-1]};
   assign dvd_next  = {dvd_ff[SUM_W-2:0], cmp.ge};

   // bar cells from the held peak, capped at the cell count
   assign scaled    = SCALED_W'(rpt_peak_ff) * SCALED_W'(BAR_CELLS);
   assign cells_raw = scaled[SCALED_W-1:FULL_SCALE_SHIFT];
   assign cells     = (cells_raw > (SCALED_W-FULL_SCALE_SHIFT)'(BAR_CELLS))
                      ? CELLS_W'(BAR_CELLS) : cells_raw[CELLS_W-1:0];

   // operand select for the shared unit
   always_comb begin
      unique case (state_ff)
         ST_DIV: begin
            op_a = MEAN_W'(div_cand);
            op_b = MEAN_W'(divisor_ff);
         end
         ST_SQRT: begin
            // root bits all sit above the trial bit, so or acts as add
            op_a = rad_ff;
            op_b = root_ff | bit_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      window_in    = csr_wr_en ? csr_wr_data : window_ff;
      mag_in       = mag_ff;
      square_in    = square_ff;
      sum_in       = sum_ff;
      peak_in      = peak_ff;
      count_in     = count_ff;
      divisor_in   = divisor_ff;
      rpt_peak_in  = rpt_peak_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               // magnitude of a two's complement sample, -32768 gives 32768
               mag_in   = req_tdata[SAMPLE_W-1] ? (LEVEL_W'(0) - req_tdata) : req_tdata;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            square_in = mag_ff * mag_ff;
            state_in  = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (count_inc < eff_window) begin
               sum_in   = sum_next;
               peak_in  = peak_next;
               count_in = count_inc;
               state_in = ST_IDLE;
            end else begin
               // window closes: hand totals to the divider, clear accumulators
               dvd_in      = sum_next;
               rpt_peak_in = peak_next;
               divisor_in  = count_inc;
               rem_in      = '0;
               sum_in      = '0;
               peak_in     = '0;
               count_in    = '0;
               step_in     = STEP_W'(DIV_STEPS - 1);
               state_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = cmp.ge ? cmp.diff[REM_W-1:0] : div_cand;
            dvd_in = dvd_next;
            if (step_ff == '0) begin
               rad_in   = dvd_next[MEAN_W-1:0];
               root_in  = '0;
               bit_in   = MEAN_W'(1) << (MEAN_W - 1);
               step_in  = STEP_W'(SQRT_STEPS - 1);
               state_in = ST_SQRT;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_SQRT: begin
            if (cmp.ge) begin
               rad_in  = cmp.diff;
               root_in = (root_ff >> 1) | bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_TDATA_W - 2 * LEVEL_W - CELLS_W){1'b0}},
                               cells, rpt_peak_ff, root_ff[LEVEL_W-1:0]};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         window_ff    <= CNT_W'(WINDOW_RESET);
         sum_ff       <= '0;
         peak_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         window_ff    <= window_in;
         sum_ff       <= sum_in;
         peak_ff      <= peak_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      square_ff   <= square_in;
      divisor_ff  <= divisor_in;
      rpt_peak_ff <= rpt_peak_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      rad_ff      <= rad_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // an accepted sample always leaves the wait state, so req_tready is low in the cycle after
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("sample accepted on back-to-back cycles");

   // levels in a report stay within full scale
   a_rms_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:0] <= 16'd32768 && rsp_tdata[31:16] <= 16'd32768))
      else $error("reported level above full scale");

   // bar count never exceeds the cell count
   a_cells_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[35:32] <= 4'(BAR_CELLS)))
      else $error("bar cells above cap");

   // the running count stays below the largest window
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff < CNT_W'(MAX_WINDOW))
      else $error("sample count overran the window");

endmodule

`default_nettype wire
